### hw/rtl/dwcl_pkg.sv
`default_nettype none
package dwcl_pkg;

    // Store size and field widths.
    localparam int MAX_ATOMS = 1024;
    localparam int AW        = $clog2(MAX_ATOMS);
    localparam int CW        = AW + 1;
    localparam int POS_W     = 24;
    localparam int FRM_W     = 10;
    localparam int CUT_W     = 48;
    localparam int DIFF_W    = POS_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int D2_W      = SQ_W + 2;
    localparam int CFG_DW    = 64;
    localparam int CFG_AW    = 6;

    // Pipeline depths of the scan and relabel passes.
    localparam int SCAN_LAT    = 5;
    localparam int RELABEL_LAT = 2;

    // Epoch value that never matches a live atom count.
    localparam logic [CW-1:0] EPOCH_CLR = '1;

    // Reset values of the cutoff registers.
    localparam logic [CUT_W-1:0] CUT_A_RST = CUT_W'(128451);
    localparam logic [CUT_W-1:0] CUT_B_RST = CUT_W'(94372);
    localparam logic [CUT_W-1:0] CUT_M_RST = CUT_W'(110756);

    // Register indexes.
    localparam logic [2:0] REG_CUT_A  = 3'd0;
    localparam logic [2:0] REG_CUT_B  = 3'd1;
    localparam logic [2:0] REG_CUT_M  = 3'd2;
    localparam logic [2:0] REG_WINDOW = 3'd3;
    localparam logic [2:0] REG_KEEP   = 3'd4;

    // Function and status codes.
    localparam logic       FUNC_ADD   = 1'b0;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BADIDX  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RELABEL,
        S_STORE,
        S_QRY1,
        S_QRY2
    } t_state;

    // One stored atom.
    typedef struct packed {
        logic             kind;
        logic [FRM_W-1:0] frame;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
    } t_atom;

    // Per-cluster record, kept at the cluster's label.
    typedef struct packed {
        logic [CW-1:0]    size;
        logic [FRM_W-1:0] minf;
    } t_clu;

    // The new atom and the link limits, as seen by the distance unit.
    typedef struct packed {
        t_atom            atom;
        logic [CUT_W-1:0] cut_a;
        logic [CUT_W-1:0] cut_b;
        logic [CUT_W-1:0] cut_m;
        logic [FRM_W-1:0] window;
    } t_probe;

endpackage
`default_nettype wire

### hw/rtl/dwcl_ram.sv
`default_nettype none
module dwcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### hw/rtl/dwcl_dist.sv
`default_nettype none
module dwcl_dist (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_vld,
    input  wire dwcl_pkg::t_atom       i_atom,
    input  wire logic [dwcl_pkg::AW-1:0] i_label,
    input  wire dwcl_pkg::t_probe      i_probe,
    output logic                       o_vld,
    output logic                       o_link,
    output logic [dwcl_pkg::AW-1:0]    o_label
);
    import dwcl_pkg::*;

    logic signed [DIFF_W-1:0] dx, dy, dz;
    logic [DIFF_W-1:0]        ax, ay, az;
    logic [CUT_W-1:0]         cut;
    logic [FRM_W-1:0]         fd;

    logic                     r_v1, r_v2;
    logic [DIFF_W-1:0]        r_ax, r_ay, r_az;
    logic [CUT_W-1:0]         r_cut1, r_cut2;
    logic                     r_fok1, r_fok2;
    logic [AW-1:0]            r_lbl1, r_lbl2;
    logic [SQ_W-1:0]          r_sx, r_sy, r_sz;
    logic [D2_W-1:0]          d2;

    // Stage one: coordinate differences, cutoff choice and frame test.
    always_comb begin
        dx = $signed({i_probe.atom.x[POS_W-1], i_probe.atom.x})
           - $signed({i_atom.x[POS_W-1], i_atom.x});
        dy = $signed({i_probe.atom.y[POS_W-1], i_probe.atom.y})
           - $signed({i_atom.y[POS_W-1], i_atom.y});
        dz = $signed({i_probe.atom.z[POS_W-1], i_probe.atom.z})
           - $signed({i_atom.z[POS_W-1], i_atom.z});
        ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        az = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
        if (!i_probe.atom.kind && !i_atom.kind) begin
            cut = i_probe.cut_a;
        end else if (i_probe.atom.kind && i_atom.kind) begin
            cut = i_probe.cut_b;
        end else begin
            cut = i_probe.cut_m;
        end
        fd = (i_probe.atom.frame > i_atom.frame) ? i_probe.atom.frame - i_atom.frame
                                                 : i_atom.frame - i_probe.atom.frame;
    end

    // Stage three: sum of squares against the cutoff.
    assign d2 = {2'b00, r_sx} + {2'b00, r_sy} + {2'b00, r_sz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            o_vld <= 1'b0;
        end else begin
            r_v1  <= i_vld;
            r_v2  <= r_v1;
            o_vld <= r_v2;
        end
        r_ax    <= ax;
        r_ay    <= ay;
        r_az    <= az;
        r_cut1  <= cut;
        r_fok1  <= (fd <= i_probe.window);
        r_lbl1  <= i_label;
        // Stage two: the three squares.
        r_sx    <= r_ax * r_ax;
        r_sy    <= r_ay * r_ay;
        r_sz    <= r_az * r_az;
        r_cut2  <= r_cut1;
        r_fok2  <= r_fok1;
        r_lbl2  <= r_lbl1;
        o_link  <= r_fok2 && (d2 < {{(D2_W-CUT_W){1'b0}}, r_cut2});
        o_label <= r_lbl2;
    end

endmodule
`default_nettype wire

### hw/rtl/distance_window_cluster_labeler.sv
// Add: a scan pass, a relabel pass and a store step run from start to the result strobe;
// the scan and relabel passes each stream the store through one read port.
// Query: label read, then cluster record read. Rejected add or bad index: answered in the cycle after start.
// One item at a time; busy stays high until its result word is out.
// Synchronous reset, then a sweep over every epoch entry clears the merge marks while busy is high.
// The result word shows for one cycle on o_done; the receiver cannot stall it.
`default_nettype none
module distance_window_cluster_labeler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dwcl_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [dwcl_pkg::CFG_DW-1:0]   pwdata,
    output logic      [dwcl_pkg::CFG_DW-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_func,
    input  wire logic                          i_atom_kind,
    input  wire logic [dwcl_pkg::FRM_W-1:0]    i_frame_number,
    input  wire logic signed [dwcl_pkg::POS_W-1:0] i_pos_x,
    input  wire logic signed [dwcl_pkg::POS_W-1:0] i_pos_y,
    input  wire logic signed [dwcl_pkg::POS_W-1:0] i_pos_z,
    input  wire logic [dwcl_pkg::AW-1:0]       i_query_index,
    output logic                               o_done,
    output logic [1:0]                         o_status,
    output logic [dwcl_pkg::AW-1:0]            o_cluster_label,
    output logic [dwcl_pkg::CW-1:0]            o_cluster_size,
    output logic                               o_cluster_kept,
    output logic [dwcl_pkg::CW-1:0]            o_atoms_stored
);
    import dwcl_pkg::*;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_count;
    logic [CUT_W-1:0]  r_cut_a, r_cut_b, r_cut_m;
    logic [FRM_W-1:0]  r_window, r_keep;
    t_atom             r_new;
    logic [AW-1:0]     r_best;
    logic [CW-1:0]     r_size;
    logic [FRM_W-1:0]  r_minf;
    logic              r_sv0;
    logic              r_e_vld, r_p_vld;
    logic [AW-1:0]     r_e_lbl, r_p_lbl;
    logic              r_rv0, r_rv1;
    logic [AW-1:0]     r_rj0, r_rj1;

    logic              accept, cfg_wr, scan_new;
    t_probe            probe;
    logic              d_vld, d_link;
    logic [AW-1:0]     d_label;

    // Memory ports.
    logic              atom_we;
    t_atom             atom_rdata;
    logic              lbl_we;
    logic [AW-1:0]     lbl_waddr, lbl_wdata, lbl_raddr, lbl_rdata;
    logic              clu_we;
    t_clu              clu_wdata, clu_rdata;
    logic [AW-1:0]     clu_raddr;
    logic              ep_we;
    logic [AW-1:0]     ep_waddr, ep_raddr;
    logic [CW-1:0]     ep_wdata, ep_rdata;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_a  <= CUT_A_RST;
            r_cut_b  <= CUT_B_RST;
            r_cut_m  <= CUT_M_RST;
            r_window <= '0;
            r_keep   <= '0;
        end else if (cfg_wr) begin
            case (paddr[CFG_AW-1:3])
                REG_CUT_A:  r_cut_a  <= pwdata[CUT_W-1:0];
                REG_CUT_B:  r_cut_b  <= pwdata[CUT_W-1:0];
                REG_CUT_M:  r_cut_m  <= pwdata[CUT_W-1:0];
                REG_WINDOW: r_window <= pwdata[FRM_W-1:0];
                REG_KEEP:   r_keep   <= pwdata[FRM_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[CFG_AW-1:3])
            REG_CUT_A:  prdata = CFG_DW'(r_cut_a);
            REG_CUT_B:  prdata = CFG_DW'(r_cut_b);
            REG_CUT_M:  prdata = CFG_DW'(r_cut_m);
            REG_WINDOW: prdata = CFG_DW'(r_window);
            REG_KEEP:   prdata = CFG_DW'(r_keep);
            default:    prdata = '0;
        endcase
    end

    // The new atom and the limits it is tested against.
    always_comb begin
        probe.atom   = r_new;
        probe.cut_a  = r_cut_a;
        probe.cut_b  = r_cut_b;
        probe.cut_m  = r_cut_m;
        probe.window = r_window;
    end

    // A linked label is new to this add unless its epoch already holds the
    // current count, or the previous cycle marked it and the write is in flight.
    assign scan_new = r_e_vld && (ep_rdata != r_count)
                   && !(r_p_vld && (r_p_lbl == r_e_lbl));

    // Next state and memory control.
    always_comb begin
        n_state   = r_state;
        atom_we   = 1'b0;
        lbl_we    = 1'b0;
        lbl_waddr = r_count[AW-1:0];
        lbl_wdata = r_best;
        lbl_raddr = (r_state == S_IDLE) ? i_query_index : r_idx[AW-1:0];
        clu_we    = 1'b0;
        clu_wdata = '{size: r_size, minf: r_minf};
        clu_raddr = d_label;
        ep_we     = 1'b0;
        ep_waddr  = r_e_lbl;
        ep_wdata  = r_count;
        ep_raddr  = d_label;
        case (r_state)
            S_CLEAR: begin
                ep_we    = 1'b1;
                ep_waddr = r_idx[AW-1:0];
                ep_wdata = EPOCH_CLR;
                if (r_idx == CW'(MAX_ATOMS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_ADD) begin
                        if (r_count < CW'(MAX_ATOMS)) begin
                            n_state = S_SCAN;
                        end
                    end else if (CW'(i_query_index) < r_count) begin
                        n_state = S_QRY1;
                    end
                end
            end
            S_SCAN: begin
                ep_we = scan_new;
                if (r_idx == r_count + CW'(SCAN_LAT)) begin
                    n_state = S_RELABEL;
                end
            end
            S_RELABEL: begin
                ep_raddr  = lbl_rdata;
                lbl_waddr = r_rj1;
                lbl_we    = r_rv1 && (ep_rdata == r_count);
                if (r_idx == r_count + CW'(RELABEL_LAT)) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                atom_we = 1'b1;
                lbl_we  = 1'b1;
                clu_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_QRY1: begin
                clu_raddr = lbl_rdata;
                n_state   = S_QRY2;
            end
            S_QRY2: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, counters and pass pipelines.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_count <= '0;
            r_sv0   <= 1'b0;
            r_e_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_rv0   <= 1'b0;
            r_rv1   <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((n_state != r_state) || (r_state == S_IDLE)) begin
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + CW'(1);
            end
            r_sv0   <= (r_state == S_SCAN) && (r_idx < r_count);
            r_e_vld <= (r_state == S_SCAN) && d_vld && d_link;
            r_p_vld <= r_e_vld;
            r_rv0   <= (r_state == S_RELABEL) && (r_idx < r_count);
            r_rv1   <= r_rv0;
            o_done  <= (accept && (n_state == S_IDLE))
                    || (r_state == S_STORE) || (r_state == S_QRY2);
            if (r_state == S_STORE) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // Payload registers: new atom, merge accumulators and the result word.
    always_ff @(posedge i_clk) begin
        r_e_lbl <= d_label;
        r_p_lbl <= r_e_lbl;
        r_rj0   <= r_idx[AW-1:0];
        r_rj1   <= r_rj0;
        if (accept) begin
            r_new  <= '{kind: i_atom_kind, frame: i_frame_number,
                        x: i_pos_x, y: i_pos_y, z: i_pos_z};
            r_best <= r_count[AW-1:0];
            r_size <= CW'(1);
            r_minf <= i_frame_number;
        end else if ((r_state == S_SCAN) && scan_new) begin
            r_size <= r_size + clu_rdata.size;
            if (clu_rdata.minf < r_minf) begin
                r_minf <= clu_rdata.minf;
            end
            if (r_e_lbl < r_best) begin
                r_best <= r_e_lbl;
            end
        end else if (r_state == S_QRY1) begin
            r_best <= lbl_rdata;
        end
        // Result word.
        if (accept) begin
            o_cluster_label <= '0;
            o_cluster_size  <= '0;
            o_cluster_kept  <= 1'b0;
            o_atoms_stored  <= r_count;
            o_status        <= (i_func == FUNC_ADD) ? ST_FULL : ST_BADIDX;
        end else if (r_state == S_STORE) begin
            o_status        <= ST_OK;
            o_cluster_label <= r_best;
            o_cluster_size  <= r_size;
            o_cluster_kept  <= (r_minf <= r_keep);
            o_atoms_stored  <= r_count + CW'(1);
        end else if (r_state == S_QRY2) begin
            o_status        <= ST_OK;
            o_cluster_label <= r_best;
            o_cluster_size  <= clu_rdata.size;
            o_cluster_kept  <= (clu_rdata.minf <= r_keep);
            o_atoms_stored  <= r_count;
        end
    end

    // Distance and link unit, used by the scan pass.
    dwcl_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_sv0),
        .i_atom  (atom_rdata),
        .i_label (lbl_rdata),
        .i_probe (probe),
        .o_vld   (d_vld),
        .o_link  (d_link),
        .o_label (d_label)
    );

    // Atom store: species, frame and position.
    dwcl_ram #(.WIDTH($bits(t_atom)), .DEPTH(MAX_ATOMS)) u_atom_ram (
        .i_clk   (i_clk),
        .i_we    (atom_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_new),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (atom_rdata)
    );

    // Cluster label of each atom.
    dwcl_ram #(.WIDTH(AW), .DEPTH(MAX_ATOMS)) u_lbl_ram (
        .i_clk   (i_clk),
        .i_we    (lbl_we),
        .i_waddr (lbl_waddr),
        .i_wdata (lbl_wdata),
        .i_raddr (lbl_raddr),
        .o_rdata (lbl_rdata)
    );

    // Size and earliest frame of each cluster, at its label.
    dwcl_ram #(.WIDTH($bits(t_clu)), .DEPTH(MAX_ATOMS)) u_clu_ram (
        .i_clk   (i_clk),
        .i_we    (clu_we),
        .i_waddr (r_best),
        .i_wdata (clu_wdata),
        .i_raddr (clu_raddr),
        .o_rdata (clu_rdata)
    );

    // Merge marks: a label is marked when its epoch equals the current count.
    dwcl_ram #(.WIDTH(CW), .DEPTH(MAX_ATOMS)) u_ep_ram (
        .i_clk   (i_clk),
        .i_we    (ep_we),
        .i_waddr (ep_waddr),
        .i_wdata (ep_wdata),
        .i_raddr (ep_raddr),
        .o_rdata (ep_rdata)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ATOMS))
        else $error("atom count beyond store size");
    a_accept_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_done))
        else $error("accepted item neither in work nor answered");
    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_OK)) |-> (o_cluster_size != '0))
        else $error("ok result with empty cluster");
    a_stored_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_atoms_stored == r_count))
        else $error("reported atom count differs from held count");
    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STORE) |-> (CW'(r_best) <= r_count))
        else $error("merged label beyond new atom index");
`endif

endmodule
`default_nettype wire
